// File: sv/asm_statement_encoder_with_fixups_core_macros.svh
// Assertion macros used by the checker file of the statement encoder
`ifndef ASM_STATEMENT_ENCODER_WITH_FIXUPS_CORE_MACROS_SVH
`define ASM_STATEMENT_ENCODER_WITH_FIXUPS_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that holds only while a condition is true
`define ASE_ASSERT_WHEN(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

// File: sv/ase_pkg.sv
// Types, codes and constants of the assembler statement encoder
package ase_pkg;

  localparam int unsigned LabelCount   = 26;
  localparam int unsigned SlotCap      = 32;
  localparam int unsigned PatchSlotsDef = 32;
  localparam int unsigned RomDepth     = 65536;
  localparam int unsigned InDataW      = 128;
  localparam int unsigned OutDataW     = 72;
  localparam int unsigned CountW       = 17;

  localparam logic [16:0] UndefAddr = 17'h1FFFF;
  localparam logic [16:0] RomLimitRst = 17'd65536;
  localparam logic [16:0] RomDepthW = 17'(RomDepth);

  localparam logic [7:0] OpAluReg  = 8'h10;
  localparam logic [7:0] OpAluImm  = 8'h20;
  localparam logic [7:0] OpAluWide = 8'h30;
  localparam logic [7:0] OpMem     = 8'h70;
  localparam logic [7:0] OpBrLbl   = 8'h80;
  localparam logic [7:0] OpBrReg   = 8'h90;
  localparam logic [7:0] OpBa      = 8'hA0;

  typedef enum logic [1:0] {
    CMD_INSN  = 2'd0,
    CMD_LABEL = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OPK_REG  = 2'd0,
    OPK_IMM  = 2'd1,
    OPK_BACK = 2'd2,
    OPK_FWD  = 2'd3
  } opk_e;

  typedef enum logic [1:0] {
    RES_WORD  = 2'd0,
    RES_PATCH = 2'd1,
    RES_ERROR = 2'd2,
    RES_DONE  = 2'd3
  } res_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_OVERFLOW   = 4'd1,
    ERR_BAD_OPS    = 4'd2,
    ERR_RANGE      = 4'd3,
    ERR_UNDEFINED  = 4'd4,
    ERR_BACK_FAR   = 4'd5,
    ERR_ABS_RANGE  = 4'd6,
    ERR_REFS_FULL  = 4'd7,
    ERR_FWD_FAR    = 4'd8,
    ERR_UNRESOLVED = 4'd9
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK_RD,
    ST_WALK,
    ST_STOP
  } state_e;

endpackage

// File: sv/ase_ram.sv
// Generic single-write, single-read RAM with registered read data
module ase_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 832
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/asm_statement_encoder_with_fixups_core.sv
// Assembler back end: statement encoder with label table and forward-reference fixups
//
// One statement enters per transaction and the block drops tready until its last
// result is loaded into the output register. An instruction, data word or end of
// source is accepted in ST_IDLE and then decoded against the label table in ST_DECODE,
// which waits on the output register. A label definition is decoded there as well
// and then walks its pending forward references: each reference is read from the
// patch memory (registered read port) in ST_WALK_RD and then checked in ST_WALK,
// relative ones through the one shared subtractor that also serves backward branch
// offsets. Forward references are held per label in a memory of LABEL_COUNT x
// min(PATCH_SLOTS, 32) entries; only written entries are ever read, so no clearing
// pass runs after reset. After an error or done result the block keeps accepting
// statements and drops them until reset. Write rom_limit only while the block is idle.
module asm_statement_encoder_with_fixups_core #(
  parameter int unsigned PATCH_SLOTS = ase_pkg::PatchSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg write channel: rom_limit
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [16:0]                   cfg_data_i,
  // tdata, low bit up: mnemonic, operand_count, op0_kind, op0_value, op1_kind,
  // op1_value, op2_kind, op2_value, label_letter, data_value, zero pad
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ase_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: cmd
  input  logic [1:0]                    s_axis_tuser_i,
  // tdata, low bit up: address, word, error_code, word_count, zero pad
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ase_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // tuser: kind
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import ase_pkg::*;

  localparam int unsigned PatchEff = (PATCH_SLOTS < SlotCap) ? PATCH_SLOTS : SlotCap;
  localparam int unsigned CntW     = $clog2(PatchEff + 1);
  localparam int unsigned RamDepth = LabelCount * PatchEff;
  localparam int unsigned RamAw    = $clog2(RamDepth);

  // Captured statement
  cmd_e        cmd_q;
  logic [5:0]  mn_q;
  logic [1:0]  nops_q;
  logic [1:0]  ty_q [3];
  logic [23:0] v_q  [3];
  logic [4:0]  lbl_q;
  logic [31:0] data_q;

  // Assembler state
  state_e      state_q, state_d;
  logic [16:0] rom_limit_q;
  logic [16:0] count_q, count_d;
  logic [16:0] label_q [LabelCount];
  logic [16:0] label_d [LabelCount];
  logic [CntW-1:0] pend_q [LabelCount];
  logic [CntW-1:0] pend_d [LabelCount];
  logic [LabelCount-1:0] pend_nz_q, pend_nz_d;

  // Patch walk
  logic [4:0]      walk_l_q, walk_l_d;
  logic [CntW-1:0] walk_i_q, walk_i_d;
  logic [CntW-1:0] walk_n_q, walk_n_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  res_e        out_kind_q, out_kind_d;
  logic [15:0] out_addr_q, out_addr_d;
  logic [31:0] out_word_q, out_word_d;
  err_e        out_err_q, out_err_d;
  logic [16:0] out_wc_q, out_wc_d;
  logic        out_last_q, out_last_d;

  // Patch memory port
  logic             ram_we, ram_re;
  logic [RamAw-1:0] ram_waddr, ram_raddr;
  logic [16:0]      ram_wdata, ram_rdata;

  logic in_fire, free;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign free    = !out_valid_q || m_axis_tready_i;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE) || (state_q == ST_STOP);

  // ---------------------------------------------------------------------------
  // Decode helpers
  // ---------------------------------------------------------------------------
  logic        is_alu, is_mem, is_br, is_ba, is_sc;
  logic [3:0]  sub_op;
  logic        rrr, rri, rrl, rr2, ri2, rl2, br_short, ba_short, sc_ok;
  err_e        val_err;
  logic [1:0]  lab_sel;
  logic [1:0]  lab_ty;
  logic [4:0]  lab_letter;
  logic        lab_ok, lab_rel;
  logic [16:0] lab_at;
  logic [16:0] lim;

  assign is_alu = (mn_q >= 6'd1)  && (mn_q <= 6'd11);
  assign is_mem = (mn_q >= 6'd12) && (mn_q <= 6'd15);
  assign is_br  = (mn_q >= 6'd16) && (mn_q <= 6'd26);
  assign is_ba  = (mn_q >= 6'd27) && (mn_q <= 6'd37);
  assign is_sc  = (mn_q == 6'd38);

  always_comb begin
    sub_op = 4'd0;
    if (is_alu) begin
      sub_op = 4'(mn_q - 6'd1);
    end else if (is_mem) begin
      sub_op = 4'(mn_q - 6'd12);
    end else if (is_br) begin
      sub_op = 4'(mn_q - 6'd16);
    end else if (is_ba) begin
      sub_op = 4'(mn_q - 6'd27);
    end
  end

  // Operand checks in operand order, first failure wins
  always_comb begin
    val_err = ERR_NONE;
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) < nops_q) && (val_err == ERR_NONE)) begin
        if ((ty_q[i] == OPK_REG) && (v_q[i] > 24'd255)) begin
          val_err = ERR_RANGE;
        end else if ((ty_q[i][1]) && (v_q[i] >= 24'(LabelCount))) begin
          val_err = ERR_BAD_OPS;
        end
      end
    end
  end

  assign rrr = (nops_q == 2'd3) && (ty_q[0] == OPK_REG) && (ty_q[1] == OPK_REG)
               && (ty_q[2] == OPK_REG);
  assign rri = (nops_q == 2'd3) && (ty_q[0] == OPK_REG) && (ty_q[1] == OPK_REG)
               && (ty_q[2] == OPK_IMM);
  assign rrl = (nops_q == 2'd3) && (ty_q[0] == OPK_REG) && (ty_q[1] == OPK_REG)
               && ty_q[2][1];
  assign rr2 = (nops_q == 2'd2) && (ty_q[0] == OPK_REG) && (ty_q[1] == OPK_REG);
  assign ri2 = (nops_q == 2'd2) && (ty_q[0] == OPK_REG) && (ty_q[1] == OPK_IMM);
  assign rl2 = (nops_q == 2'd2) && (ty_q[0] == OPK_REG) && ty_q[1][1];
  assign br_short = (sub_op == 4'd0) && (nops_q == 2'd1) && ty_q[0][1];
  assign ba_short = (sub_op == 4'd0) && (nops_q == 2'd1) && (ty_q[0] == OPK_REG);
  assign sc_ok    = (nops_q == 2'd1) && (ty_q[0] == OPK_IMM);

  // Pick the label operand: absolute for ALU forms, relative for branches
  always_comb begin
    if (is_alu) begin
      lab_sel = 2'd1;
    end else if (br_short) begin
      lab_sel = 2'd0;
    end else begin
      lab_sel = 2'd2;
    end
  end

  assign lab_ty     = ty_q[lab_sel];
  assign lab_letter = v_q[lab_sel][4:0];
  assign lab_ok     = (v_q[lab_sel] < 24'(LabelCount));
  assign lab_rel    = !is_alu;
  assign lab_at     = lab_ok ? label_q[lab_letter] : UndefAddr;
  assign lim        = (rom_limit_q > RomDepthW) ? RomDepthW : rom_limit_q;

  // Shared subtractor: a - b - 1, sign in bit 18
  logic [16:0] sub_a, sub_b;
  logic [18:0] sub_d;
  always_comb begin
    if (state_q == ST_WALK) begin
      sub_a = count_q;
      sub_b = {1'b0, ram_rdata[15:0]};
    end else begin
      sub_a = lab_at;
      sub_b = count_q;
    end
  end
  assign sub_d = {2'b00, sub_a} - {2'b00, sub_b} - 19'd1;

  // Label resolve
  err_e        res_err;
  logic [15:0] res_off;
  logic        res_push;
  always_comb begin
    res_err  = ERR_NONE;
    res_off  = 16'd0;
    res_push = 1'b0;
    if (lab_ty == OPK_BACK) begin
      if (lab_at == UndefAddr) begin
        res_err = ERR_UNDEFINED;
      end else if (lab_rel) begin
        if ($signed(sub_d) < -19'sd128) begin
          res_err = ERR_BACK_FAR;
        end
        res_off = {8'd0, sub_d[7:0]};
      end else begin
        if (lab_at[16]) begin
          res_err = ERR_ABS_RANGE;
        end
        res_off = lab_at[15:0];
      end
    end else if (pend_q[lab_letter] >= CntW'(PatchEff)) begin
      res_err = ERR_REFS_FULL;
    end else begin
      res_push = 1'b1;
    end
  end

  // Instruction encode
  err_e        ins_err;
  logic [31:0] ins_word;
  logic        ins_push;
  logic [7:0]  r0, r1, r2;
  assign r0 = v_q[0][7:0];
  assign r1 = v_q[1][7:0];
  assign r2 = v_q[2][7:0];

  always_comb begin
    ins_err  = ERR_NONE;
    ins_word = 32'd0;
    ins_push = 1'b0;
    if (val_err != ERR_NONE) begin
      ins_err = val_err;
    end else if (is_alu) begin
      if (rrr) begin
        ins_word = {OpAluReg + 8'(sub_op), r0, r1, r2};
      end else if (rri) begin
        if (v_q[2] > 24'd255) ins_err = ERR_RANGE;
        ins_word = {OpAluImm + 8'(sub_op), r0, r1, r2};
      end else if (rr2) begin
        ins_word = {OpAluReg + 8'(sub_op), r0, r0, r1};
      end else if (ri2) begin
        if (v_q[1] > 24'hFFFF) ins_err = ERR_RANGE;
        ins_word = {OpAluWide + 8'(sub_op), r0, v_q[1][15:0]};
      end else if (rl2) begin
        ins_err  = res_err;
        ins_push = res_push;
        ins_word = {OpAluWide + 8'(sub_op), r0, res_off};
      end else begin
        ins_err = ERR_BAD_OPS;
      end
    end else if (is_mem) begin
      if (!rri) begin
        ins_err = ERR_BAD_OPS;
      end else if (v_q[2] > 24'd255) begin
        ins_err = ERR_RANGE;
      end
      ins_word = {OpMem + 8'(sub_op), r0, r1, r2};
    end else if (is_br) begin
      if (br_short) begin
        ins_err  = res_err;
        ins_push = res_push;
        ins_word = {OpBrLbl, 16'd0, res_off[7:0]};
      end else if (rrr) begin
        ins_word = {OpBrReg + 8'(sub_op), r0, r1, r2};
      end else if (rrl) begin
        ins_err  = res_err;
        ins_push = res_push;
        ins_word = {OpBrLbl + 8'(sub_op), r0, r1, res_off[7:0]};
      end else begin
        ins_err = ERR_BAD_OPS;
      end
    end else if (is_ba) begin
      if (ba_short) begin
        ins_word = {OpBa, r0, r0, r0};
      end else if (rrr) begin
        ins_word = {OpBa + 8'(sub_op), r0, r1, r2};
      end else begin
        ins_err = ERR_BAD_OPS;
      end
    end else if (is_sc) begin
      if (!sc_ok) ins_err = ERR_BAD_OPS;
      ins_word = {8'd0, v_q[0]};
    end else begin
      ins_err = ERR_BAD_OPS;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    label_d     = label_q;
    pend_d      = pend_q;
    pend_nz_d   = pend_nz_q;
    walk_l_d    = walk_l_q;
    walk_i_d    = walk_i_q;
    walk_n_d    = walk_n_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_kind_d  = out_kind_q;
    out_addr_d  = out_addr_q;
    out_word_d  = out_word_q;
    out_err_d   = out_err_q;
    out_wc_d    = out_wc_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = RamAw'(32'(lab_letter) * PatchEff + 32'(pend_q[lab_letter]));
    ram_wdata   = {lab_rel, count_q[15:0]};
    ram_re      = 1'b0;
    ram_raddr   = RamAw'(32'(walk_l_q) * PatchEff + 32'(walk_i_q));

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_DECODE;
      end
      ST_STOP: begin
        // drop every statement until reset
      end
      ST_DECODE: begin
        if (free) begin
          out_valid_d = 1'b1;
          out_kind_d  = RES_ERROR;
          out_addr_d  = 16'd0;
          out_word_d  = 32'd0;
          out_err_d   = ERR_NONE;
          out_wc_d    = count_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
          unique case (cmd_q)
            CMD_INSN, CMD_DATA: begin
              if ((cmd_q == CMD_INSN) && (ins_err != ERR_NONE)) begin
                out_err_d = ins_err;
                state_d   = ST_STOP;
              end else if (count_q >= lim) begin
                out_err_d = ERR_OVERFLOW;
                state_d   = ST_STOP;
              end else begin
                out_kind_d = RES_WORD;
                out_addr_d = count_q[15:0];
                out_word_d = (cmd_q == CMD_INSN) ? ins_word : data_q;
                out_wc_d   = 17'd0;
                count_d    = count_q + 17'd1;
              end
              if ((cmd_q == CMD_INSN) && ins_push && (ins_err == ERR_NONE)) begin
                ram_we                 = 1'b1;
                pend_d[lab_letter]     = pend_q[lab_letter] + CntW'(1);
                pend_nz_d[lab_letter]  = 1'b1;
              end
            end
            CMD_LABEL: begin
              if (lbl_q >= 5'(LabelCount)) begin
                out_err_d = ERR_BAD_OPS;
                state_d   = ST_STOP;
              end else begin
                out_valid_d    = out_valid_q && !m_axis_tready_i;
                label_d[lbl_q] = count_q;
                walk_l_d       = lbl_q;
                walk_i_d       = '0;
                walk_n_d       = pend_q[lbl_q];
                if (pend_q[lbl_q] != '0) state_d = ST_WALK_RD;
              end
            end
            CMD_END: begin
              out_kind_d = (pend_nz_q != '0) ? RES_ERROR : RES_DONE;
              out_err_d  = (pend_nz_q != '0) ? ERR_UNRESOLVED : ERR_NONE;
              state_d    = ST_STOP;
            end
            default: ;
          endcase
        end
      end
      ST_WALK_RD: begin
        ram_re  = 1'b1;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (free) begin
          out_valid_d = 1'b1;
          out_addr_d  = ram_rdata[15:0];
          out_wc_d    = 17'd0;
          out_err_d   = ERR_NONE;
          out_kind_d  = RES_PATCH;
          out_last_d  = (walk_i_q + CntW'(1) == walk_n_q);
          if (ram_rdata[16]) begin
            out_word_d = {24'd0, sub_d[7:0]};
            if (sub_d[18:8] != '0) out_err_d = ERR_FWD_FAR;
          end else begin
            out_word_d = {15'd0, count_q};
            if (count_q[16]) out_err_d = ERR_ABS_RANGE;
          end
          if (out_err_d != ERR_NONE) begin
            out_kind_d = RES_ERROR;
            out_addr_d = 16'd0;
            out_word_d = 32'd0;
            out_wc_d   = count_q;
            out_last_d = 1'b1;
            state_d    = ST_STOP;
          end else if (out_last_d) begin
            pend_d[walk_l_q]    = '0;
            pend_nz_d[walk_l_q] = 1'b0;
            state_d             = ST_IDLE;
          end else begin
            walk_i_d = walk_i_q + CntW'(1);
            state_d  = ST_WALK_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rom_limit_q <= RomLimitRst;
      count_q     <= '0;
      pend_nz_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LabelCount; i++) begin
        label_q[i] <= UndefAddr;
        pend_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_nz_q   <= pend_nz_d;
      out_valid_q <= out_valid_d;
      label_q     <= label_d;
      pend_q      <= pend_d;
      if (cfg_valid_i && cfg_ready_o) rom_limit_q <= cfg_data_i;
    end
  end

  // Payload: statement capture, walk pointers and output fields
  always_ff @(posedge clk_i) begin
    if (in_fire && (state_q == ST_IDLE)) begin
      cmd_q   <= cmd_e'(s_axis_tuser_i);
      mn_q    <= s_axis_tdata_i[5:0];
      nops_q  <= s_axis_tdata_i[7:6];
      ty_q[0] <= s_axis_tdata_i[9:8];
      v_q[0]  <= s_axis_tdata_i[33:10];
      ty_q[1] <= s_axis_tdata_i[35:34];
      v_q[1]  <= s_axis_tdata_i[59:36];
      ty_q[2] <= s_axis_tdata_i[61:60];
      v_q[2]  <= s_axis_tdata_i[85:62];
      lbl_q   <= s_axis_tdata_i[90:86];
      data_q  <= s_axis_tdata_i[122:91];
    end
    walk_l_q   <= walk_l_d;
    walk_i_q   <= walk_i_d;
    walk_n_q   <= walk_n_d;
    out_kind_q <= out_kind_d;
    out_addr_q <= out_addr_d;
    out_word_q <= out_word_d;
    out_err_q  <= out_err_d;
    out_wc_q   <= out_wc_d;
    out_last_q <= out_last_d;
  end

  ase_ram #(
    .Width(17),
    .Depth(RamDepth)
  ) u_patch_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {3'd0, out_wc_q, out_err_q, out_word_q, out_addr_q};

endmodule

// File: sv/ase_checker.sv
// Port-level checker for the statement encoder, bound to the top level
`include "asm_statement_encoder_with_fixups_core_macros.svh"

module ase_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [ase_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [1:0]                   m_axis_tuser_o,
  input logic                         m_axis_tlast_o
);
  import ase_pkg::*;

  logic is_end;
  assign is_end = m_axis_tvalid_o &&
                  ((m_axis_tuser_o == RES_ERROR) || (m_axis_tuser_o == RES_DONE));

  `ASE_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")
  `ASE_ASSERT_WHEN(a_end_last, clk_i, rst_ni, is_end, m_axis_tlast_o && (m_axis_tdata_o[47:0] == 48'd0), "error or done not final or not cleared")
  `ASE_ASSERT_WHEN(a_err_code, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o == RES_ERROR), m_axis_tdata_o[51:48] != 4'd0, "error result without code")
  `ASE_ASSERT_WHEN(a_word_clean, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[1], m_axis_tdata_o[68:48] == 21'd0, "word or patch carries status")

endmodule

bind asm_statement_encoder_with_fixups_core ase_checker u_ase_checker (.*);

// File: dv/tb_asm_statement_encoder_with_fixups_core.sv
// Testbench for the assembler statement encoder: directed and random statements, scoreboard
`timescale 1ns / 100ps

module tb_asm_statement_encoder_with_fixups_core;
  import ase_pkg::*;

  // Mnemonic groups of the statement stream
  localparam logic [5:0] MnMov    = 6'd1;
  localparam logic [5:0] MnAluTop = 6'd11;
  localparam logic [5:0] MnLd     = 6'd12;
  localparam logic [5:0] MnMemTop = 6'd15;
  localparam logic [5:0] MnBr     = 6'd16;
  localparam logic [5:0] MnBrTop  = 6'd26;
  localparam logic [5:0] MnBa     = 6'd27;
  localparam logic [5:0] MnBaTop  = 6'd37;
  localparam logic [5:0] MnSc     = 6'd38;

  localparam int unsigned RegMax    = 255;
  localparam int unsigned WalkDrain = 80;    // room for a quiet label walk to finish
  localparam int unsigned CycleCap  = 400000;

  // Ways the run is allowed to terminate
  typedef enum int {
    END_CLEAN,
    END_OVERFLOW,
    END_REFS_FULL,
    END_NOISE
  } ending_e;

  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  mnem;
    logic [1:0]  nops;
    logic [1:0]  opk [3];
    logic [23:0] opv [3];
    logic [4:0]  letter;
    logic [31:0] data;
  } stmt_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [31:0] word;
    logic [3:0]  err;
    logic [16:0] cnt;
    logic        last;
  } result_t;

  // Architectural state of the encoder, kept whole so a trial step can be undone
  typedef struct {
    int unsigned emitted;
    int unsigned lbl_addr [LabelCount];
    int unsigned pend_cnt [LabelCount];
    int unsigned pend_ref [LabelCount*SlotCap];
    bit          stopped;
  } enc_state_t;

  class stmt_scoreboard;
    enc_state_t  st;
    int unsigned rom_limit;
    result_t     awaited_results[$];
    result_t     scratch[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned statements;

    function new();
      st.emitted = 0;
      foreach (st.lbl_addr[i]) begin
        st.lbl_addr[i] = UndefAddr;
        st.pend_cnt[i] = 0;
      end
      foreach (st.pend_ref[i]) st.pend_ref[i] = 0;
      st.stopped  = 0;
      rom_limit   = RomLimitRst;
      mismatches  = 0;
      checked     = 0;
      statements  = 0;
    endfunction

    function void put(logic [1:0] kind, int unsigned addr, logic [31:0] word,
                      logic [3:0] err, int unsigned cnt);
      result_t r;
      r.kind = kind;
      r.addr = addr[15:0];
      r.word = word;
      r.err  = err;
      r.cnt  = cnt[16:0];
      r.last = 0;
      scratch.push_back(r);
    endfunction

    function void fail(logic [3:0] err);
      st.stopped = 1;
      put(RES_ERROR, 0, 0, err, st.emitted);
    endfunction

    function void emit_word(logic [31:0] w);
      int unsigned lim;
      lim = (rom_limit > RomDepth) ? RomDepth : rom_limit;
      if (st.emitted >= lim) begin
        fail(ERR_OVERFLOW);
        return;
      end
      put(RES_WORD, st.emitted, w, ERR_NONE, 0);
      st.emitted++;
    endfunction

    // Resolve a label operand into offset bits, or queue a fixup for a forward one
    function logic [3:0] resolve(logic [1:0] kind, int unsigned letter, bit rel,
                                 output int unsigned off);
      int unsigned at;
      off = 0;
      if (letter >= LabelCount) return ERR_BAD_OPS;
      if (kind == OPK_BACK) begin
        at = st.lbl_addr[letter];
        if (at == UndefAddr) return ERR_UNDEFINED;
        if (rel) begin
          if (at + 32'h80 < st.emitted + 1) return ERR_BACK_FAR;
          off = (at - (st.emitted + 1)) & 32'hFF;
        end else begin
          if (at > 32'hFFFF) return ERR_ABS_RANGE;
          off = at;
        end
        return ERR_NONE;
      end
      if (st.pend_cnt[letter] >= ((PatchSlotsDef < SlotCap) ? PatchSlotsDef : SlotCap))
        return ERR_REFS_FULL;
      st.pend_ref[letter*SlotCap + st.pend_cnt[letter]] =
        (st.emitted & 32'hFFFF) | (rel ? 32'h10000 : 0);
      st.pend_cnt[letter]++;
      return ERR_NONE;
    endfunction

    // Bind a label here and release its queued fixups as OR patches
    function void define_label(int unsigned l);
      int unsigned n, e, a, bits;
      if (l >= LabelCount) begin
        fail(ERR_BAD_OPS);
        return;
      end
      n = st.emitted;
      st.lbl_addr[l] = n;
      for (int unsigned i = 0; i < st.pend_cnt[l] && i < SlotCap; i++) begin
        e = st.pend_ref[l*SlotCap + i];
        a = e & 32'hFFFF;
        if (e & 32'h10000) begin
          bits = n - (a + 1);
          if (bits > 32'hFF) begin
            fail(ERR_FWD_FAR);
            return;
          end
        end else begin
          if (n > 32'hFFFF) begin
            fail(ERR_ABS_RANGE);
            return;
          end
          bits = n;
        end
        put(RES_PATCH, a, bits, ERR_NONE, 0);
      end
      st.pend_cnt[l] = 0;
    endfunction

    function void encode(stmt_t s);
      logic [1:0]  ty [3];
      int unsigned v [3];
      int unsigned m, c, off;
      logic [3:0]  e;
      bit rrr, rri, rrl;
      m = s.mnem;
      for (int i = 0; i < 3; i++) begin
        ty[i] = s.opk[i];
        v[i]  = s.opv[i];
      end
      // register range first, then label letter, in operand order
      for (int i = 0; i < s.nops; i++) begin
        if (ty[i] == OPK_REG && v[i] > RegMax) begin
          fail(ERR_RANGE);
          return;
        end
        if (ty[i] >= OPK_BACK && v[i] >= LabelCount) begin
          fail(ERR_BAD_OPS);
          return;
        end
      end
      rrr = s.nops == 3 && ty[0] == OPK_REG && ty[1] == OPK_REG && ty[2] == OPK_REG;
      rri = s.nops == 3 && ty[0] == OPK_REG && ty[1] == OPK_REG && ty[2] == OPK_IMM;
      rrl = s.nops == 3 && ty[0] == OPK_REG && ty[1] == OPK_REG && ty[2] >= OPK_BACK;
      if (m >= MnMov && m <= MnAluTop) begin
        c = m - MnMov;
        if (rrr) begin
          emit_word({OpAluReg + 8'(c), v[0][7:0], v[1][7:0], v[2][7:0]});
        end else if (rri) begin
          if (v[2] > RegMax) fail(ERR_RANGE);
          else emit_word({OpAluImm + 8'(c), v[0][7:0], v[1][7:0], v[2][7:0]});
        end else if (s.nops == 2 && ty[0] == OPK_REG && ty[1] == OPK_REG) begin
          emit_word({OpAluReg + 8'(c), v[0][7:0], v[0][7:0], v[1][7:0]});
        end else if (s.nops == 2 && ty[0] == OPK_REG && ty[1] == OPK_IMM) begin
          if (v[1] > 32'hFFFF) fail(ERR_RANGE);
          else emit_word({OpAluWide + 8'(c), v[0][7:0], v[1][15:0]});
        end else if (s.nops == 2 && ty[0] == OPK_REG && ty[1] >= OPK_BACK) begin
          e = resolve(ty[1], v[1], 0, off);
          if (e != ERR_NONE) fail(e);
          else emit_word({OpAluWide + 8'(c), v[0][7:0], off[15:0]});
        end else begin
          fail(ERR_BAD_OPS);
        end
      end else if (m >= MnLd && m <= MnMemTop) begin
        if (!rri) fail(ERR_BAD_OPS);
        else if (v[2] > RegMax) fail(ERR_RANGE);
        else emit_word({OpMem + 8'(m - MnLd), v[0][7:0], v[1][7:0], v[2][7:0]});
      end else if (m >= MnBr && m <= MnBrTop) begin
        c = m - MnBr;
        // plain br with a lone label operand branches with zero registers
        if (c == 0 && s.nops == 1 && ty[0] >= OPK_BACK) begin
          ty[2] = ty[0];
          v[2]  = v[0];
          v[0]  = 0;
          v[1]  = 0;
          rrr   = 0;
          rrl   = 1;
        end
        if (rrr) begin
          emit_word({OpBrReg + 8'(c), v[0][7:0], v[1][7:0], v[2][7:0]});
        end else if (rrl) begin
          e = resolve(ty[2], v[2], 1, off);
          if (e != ERR_NONE) fail(e);
          else emit_word({OpBrLbl + 8'(c), v[0][7:0], v[1][7:0], off[7:0]});
        end else begin
          fail(ERR_BAD_OPS);
        end
      end else if (m >= MnBa && m <= MnBaTop) begin
        c = m - MnBa;
        if (c == 0 && s.nops == 1 && ty[0] == OPK_REG)
          emit_word({OpBa, v[0][7:0], v[0][7:0], v[0][7:0]});
        else if (rrr) emit_word({OpBa + 8'(c), v[0][7:0], v[1][7:0], v[2][7:0]});
        else fail(ERR_BAD_OPS);
      end else if (m == MnSc) begin
        if (s.nops == 1 && ty[0] == OPK_IMM) emit_word({8'h00, s.opv[0]});
        else fail(ERR_BAD_OPS);
      end else begin
        fail(ERR_BAD_OPS);
      end
    endfunction

    function void step(stmt_t s);
      bit open;
      scratch.delete();
      if (st.stopped) return;
      case (s.cmd)
        CMD_INSN:  encode(s);
        CMD_LABEL: define_label(s.letter);
        CMD_DATA:  emit_word(s.data);
        default: begin
          open = 0;
          foreach (st.pend_cnt[i]) if (st.pend_cnt[i] != 0) open = 1;
          if (open) fail(ERR_UNRESOLVED);
          else begin
            st.stopped = 1;
            put(RES_DONE, 0, 0, ERR_NONE, st.emitted);
          end
        end
      endcase
      if (scratch.size() > 0) scratch[scratch.size()-1].last = 1;
    endfunction

    // Trial step: does this statement end the program? State is left untouched.
    function bit would_stop(stmt_t s);
      enc_state_t keep;
      bit r;
      keep = st;
      step(s);
      r = st.stopped;
      st = keep;
      return r;
    endfunction

    function void note_statement(stmt_t s);
      statements++;
      step(s);
      foreach (scratch[i]) awaited_results.push_back(scratch[i]);
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d addr=%h word=%h err=%0d cnt=%0d",
                   got.kind, got.addr, got.word, got.err, got.cnt);
        return;
      end
      want = awaited_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp kind=%0d addr=%h word=%h err=%0d cnt=%0d last=%0d",
                    " got kind=%0d addr=%h word=%h err=%0d cnt=%0d last=%0d"},
                   want.kind, want.addr, want.word, want.err, want.cnt, want.last,
                   got.kind, got.addr, got.word, got.err, got.cnt, got.last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [16:0] cfg_data_i;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [InDataW-1:0] s_axis_tdata_i;
  logic [1:0] s_axis_tuser_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  asm_statement_encoder_with_fixups_core dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  stmt_scoreboard sb = new();
  bit          gaps_on;      // random idle bursts on both sides
  bit          long_stall;   // ask the receiver for one long hold-off
  int unsigned cycles;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back the block up
  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready_i <= 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        long_stall = 0;
        hold = 300;
      end
      if (hold > 0) begin
        m_axis_tready_i <= 0;
        hold--;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 0;
        hold = $urandom_range(0, 3);
      end else begin
        m_axis_tready_i <= 1;
      end
    end
  end

  // Collect every result transaction
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      r.kind = m_axis_tuser_o;
      r.addr = m_axis_tdata_o[15:0];
      r.word = m_axis_tdata_o[47:16];
      r.err  = m_axis_tdata_o[51:48];
      r.cnt  = m_axis_tdata_o[68:52];
      r.last = m_axis_tlast_o;
      sb.check_result(r);
    end
  end

  // Offer one statement; note it when the transaction completes
  task automatic send_stmt(stmt_t s);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i  <= s.cmd;
    s_axis_tdata_i  <= {5'b0, s.data, s.letter, s.opv[2], s.opk[2], s.opv[1], s.opk[1],
                        s.opv[0], s.opk[0], s.nops, s.mnem};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_statement(s);
  endtask

  // Hold the stream, wait for all results, then let a quiet label walk finish
  task automatic drain();
    s_axis_tvalid_i <= 0;
    do @(posedge clk_i); while (sb.awaited_results.size() != 0);
    repeat (WalkDrain) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned lim);
    cfg_valid_i <= 1;
    cfg_data_i  <= lim[16:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.rom_limit = lim;
  endtask

  function automatic stmt_t blank(logic [1:0] cmd);
    stmt_t s;
    s.cmd    = cmd;
    s.mnem   = $urandom_range(0, 63);
    s.nops   = 0;
    for (int i = 0; i < 3; i++) begin
      s.opk[i] = $urandom_range(0, 3);
      s.opv[i] = $urandom;
    end
    s.letter = $urandom_range(0, 31);
    s.data   = $urandom;
    return s;
  endfunction

  function automatic stmt_t insn(logic [5:0] m, logic [1:0] n,
                                 logic [1:0] k0, int unsigned v0,
                                 logic [1:0] k1, int unsigned v1,
                                 logic [1:0] k2, int unsigned v2);
    stmt_t s;
    s = blank(CMD_INSN);
    s.mnem = m;
    s.nops = n;
    // unused operand slots keep their random junk
    if (n > 0) begin s.opk[0] = k0; s.opv[0] = v0; end
    if (n > 1) begin s.opk[1] = k1; s.opv[1] = v1; end
    if (n > 2) begin s.opk[2] = k2; s.opv[2] = v2; end
    return s;
  endfunction

  function automatic stmt_t label_def(int unsigned l);
    stmt_t s;
    s = blank(CMD_LABEL);
    s.letter = l;
    return s;
  endfunction

  function automatic stmt_t data_word(logic [31:0] w);
    stmt_t s;
    s = blank(CMD_DATA);
    s.data = w;
    return s;
  endfunction

  // One well-formed statement with random content
  function automatic stmt_t random_stmt();
    int unsigned r0, r1, r2, lt;
    logic [1:0] lk;
    r0 = $urandom_range(0, RegMax);
    r1 = $urandom_range(0, RegMax);
    r2 = $urandom_range(0, RegMax);
    lt = $urandom_range(0, LabelCount - 1);
    lk = $urandom_range(0, 1) ? OPK_FWD : OPK_BACK;
    case ($urandom_range(0, 12))
      0: return insn($urandom_range(MnMov, MnAluTop), 3, OPK_REG, r0, OPK_REG, r1,
                     OPK_REG, r2);
      1: return insn($urandom_range(MnMov, MnAluTop), 3, OPK_REG, r0, OPK_REG, r1,
                     OPK_IMM, r2);
      2: return insn($urandom_range(MnMov, MnAluTop), 2, OPK_REG, r0, OPK_REG, r1, 0, 0);
      3: return insn($urandom_range(MnMov, MnAluTop), 2, OPK_REG, r0, OPK_IMM,
                     $urandom_range(0, 16'hFFFF), 0, 0);
      4: return insn($urandom_range(MnMov, MnAluTop), 2, OPK_REG, r0, lk, lt, 0, 0);
      5: return insn($urandom_range(MnLd, MnMemTop), 3, OPK_REG, r0, OPK_REG, r1,
                     OPK_IMM, r2);
      6: return insn($urandom_range(MnBr, MnBrTop), 3, OPK_REG, r0, OPK_REG, r1,
                     OPK_REG, r2);
      7: return insn($urandom_range(MnBr, MnBrTop), 3, OPK_REG, r0, OPK_REG, r1, lk, lt);
      8: return insn(MnBr, 1, lk, lt, 0, 0, 0, 0);
      9: return $urandom_range(0, 1) ? insn(MnBa, 1, OPK_REG, r0, 0, 0, 0, 0)
              : insn($urandom_range(MnBa, MnBaTop), 3, OPK_REG, r0, OPK_REG, r1,
                     OPK_REG, r2);
      10: return insn(MnSc, 1, OPK_IMM, $urandom_range(0, 24'hFFFFFF), 0, 0, 0, 0);
      11: return data_word($urandom);
      default: begin
        // favor letters that still wait on fixups
        for (int i = 0; i < 8; i++) begin
          if (sb.st.pend_cnt[lt] != 0) break;
          lt = $urandom_range(0, LabelCount - 1);
        end
        return label_def(lt);
      end
    endcase
  endfunction

  // Random statements that keep the program alive; fall back to a data word
  task automatic random_run(int unsigned count);
    stmt_t s;
    for (int unsigned n = 0; n < count; n++) begin
      for (int t = 0; t < 20; t++) begin
        s = random_stmt();
        if (!sb.would_stop(s)) break;
        s = data_word($urandom);
      end
      send_stmt(s);
    end
  endtask

  initial begin
    stmt_t   s;
    ending_e how;
    string   how_name;
    gaps_on         = 1;
    long_stall      = 0;
    cfg_valid_i     <= 0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    rst_ni          <= 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Limit of one word: exactly one word fits
    write_limit(1);
    send_stmt(data_word(32'hFFFF_FFFF));
    drain();
    write_limit(RomLimitRst);

    // Directed: every operation form and the operand extremes
    send_stmt(label_def(0));
    send_stmt(insn(MnMov, 3, OPK_REG, 255, OPK_REG, 0, OPK_REG, 255));
    send_stmt(insn(MnMov + 1, 3, OPK_REG, 0, OPK_REG, 255, OPK_IMM, 255));
    send_stmt(insn(MnMov + 2, 2, OPK_REG, 170, OPK_REG, 85, 0, 0));
    send_stmt(insn(MnAluTop, 2, OPK_REG, 1, OPK_IMM, 16'hFFFF, 0, 0));
    send_stmt(insn(MnMov + 3, 2, OPK_REG, 7, OPK_FWD, 25, 0, 0));
    send_stmt(insn(MnMov + 4, 2, OPK_REG, 8, OPK_BACK, 0, 0, 0));
    for (int m = MnLd; m <= MnMemTop; m++)
      send_stmt(insn(m, 3, OPK_REG, m, OPK_REG, 255, OPK_IMM, 128));
    send_stmt(insn(MnBrTop, 3, OPK_REG, 3, OPK_REG, 4, OPK_REG, 5));
    send_stmt(insn(MnBr + 5, 3, OPK_REG, 9, OPK_REG, 10, OPK_FWD, 25));
    send_stmt(insn(MnBr, 1, OPK_BACK, 0, 0, 0, 0, 0));
    send_stmt(insn(MnBr, 1, OPK_FWD, 16, 0, 0, 0, 0));
    send_stmt(insn(MnBa, 1, OPK_REG, 200, 0, 0, 0, 0));
    send_stmt(insn(MnBaTop, 3, OPK_REG, 1, OPK_REG, 2, OPK_REG, 3));
    send_stmt(insn(MnSc, 1, OPK_IMM, 24'hFFFFFF, 0, 0, 0, 0));
    send_stmt(data_word(32'h0));
    send_stmt(label_def(25));
    send_stmt(label_def(16));
    send_stmt(label_def(25));   // redefinition with nothing queued
    random_run(30);
    drain();

    // Mid-range limit, well above what the program needs; one long output stall
    write_limit($urandom_range(sb.st.emitted + 200, RomDepth - 1));
    random_run(20);
    long_stall = 1;
    random_run(35);
    drain();

    // Terminate the program one way or another, without idling
    gaps_on = 0;
    how = ending_e'($urandom_range(0, 3));
    case (how)
      END_OVERFLOW: begin
        write_limit(sb.st.emitted);
        send_stmt(data_word($urandom));
      end
      END_REFS_FULL: begin
        for (int i = 0; i <= SlotCap; i++) send_stmt(insn(MnBr, 1, OPK_FWD, 24, 0, 0, 0, 0));
      end
      END_NOISE: begin
        for (int i = 0; i < 40 && !sb.st.stopped; i++) begin
          s = blank($urandom_range(0, 2));
          s.nops = $urandom_range(0, 3);
          send_stmt(s);
        end
      end
      default: ;
    endcase
    // Resolve what is still open and close the source; ignored if already stopped
    for (int l = 0; l < LabelCount; l++)
      if (sb.st.pend_cnt[l] != 0) send_stmt(label_def(l));
    send_stmt(blank(CMD_END));
    // Statements after the stop must be swallowed
    for (int i = 0; i < 4; i++) send_stmt(random_stmt());
    s_axis_tvalid_i <= 0;

    for (int i = 0; i < 20000 && sb.awaited_results.size() != 0; i++) @(posedge clk_i);
    repeat (WalkDrain) @(posedge clk_i);
    if (sb.awaited_results.size() != 0) sb.mismatches++;

    how_name = how.name();
    $display("run: %0d statements, %0d results checked, %0d words emitted, ending %s",
             sb.statements, sb.checked, sb.st.emitted, how_name);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/ase_pkg.sv
sv/ase_ram.sv
sv/asm_statement_encoder_with_fixups_core.sv
sv/ase_checker.sv
dv/tb_asm_statement_encoder_with_fixups_core.sv
